[rtl/core/slot_arena_allocator_assert.svh]
// Assertion macros for the slot arena allocator RTL
`ifndef SLOT_ARENA_ALLOCATOR_ASSERT_SVH
`define SLOT_ARENA_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SAA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("slot arena allocator check failed");
// Check a property on every clock edge, reset included
`define SAA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("slot arena allocator check failed");
`else
`define SAA_ASSERT(lbl, prop)
`define SAA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/saa_pkg.sv]
// Shared types and constants of the slot arena allocator
`timescale 1ns / 1ps
`default_nettype none
package saa_pkg;
    localparam int SLOTS_PER_BLK = 64;
    localparam int MAX_BLOCKS    = 16;
    localparam int IDX_W         = 6;
    localparam int BLK_W         = 4;
    localparam int OPEN_W        = 5;
    localparam int LIVE_W        = 11;
    localparam int SKIP_W        = 32;
    localparam int FF_W          = 9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic done_now;
        logic hit;
    } sts_t;
endpackage
`default_nettype wire

[rtl/core/saa_ctrl.sv]
// Request sequencer of the slot arena allocator
`timescale 1ns / 1ps
`default_nettype none
module saa_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire saa_pkg::sts_t sts,
    output saa_pkg::cmd_t      cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // Advance through accept, execute, scan and hand-off
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.done_now ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.hit)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
            valid_next = 1'b0;
        if (cmd.load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end
endmodule
`default_nettype wire

[rtl/core/saa_dp.sv]
// Slot bitmap, counters and scan datapath of the slot arena allocator
`timescale 1ns / 1ps
`default_nettype none
`include "slot_arena_allocator_assert.svh"
module saa_dp
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [saa_pkg::FF_W-1:0]    cfg_wdata,
    input  wire logic                        in_req,
    input  wire logic [saa_pkg::BLK_W-1:0]   in_blk,
    input  wire logic [saa_pkg::IDX_W-1:0]   in_slot,
    input  wire saa_pkg::cmd_t               cmd,
    output saa_pkg::sts_t                    sts,
    output logic [71:0]                      out_data,
    output logic [1:0]                       out_status
);
    localparam logic [saa_pkg::IDX_W-1:0] TOP_IDX =
        saa_pkg::IDX_W'(saa_pkg::SLOTS_PER_BLK - 1);

    logic [saa_pkg::SLOTS_PER_BLK-1:0] used_map_reg [saa_pkg::MAX_BLOCKS];
    logic [saa_pkg::OPEN_W-1:0]     opened_reg;
    logic [saa_pkg::BLK_W-1:0]      cur_reg;
    logic [saa_pkg::IDX_W-1:0]      scan_reg;
    logic [saa_pkg::LIVE_W-1:0]     live_reg, peak_reg;
    logic [saa_pkg::SKIP_W-1:0]     skips_reg;
    logic [saa_pkg::FF_W-1:0]       ff_reg;
    logic                           req_reg;
    logic [saa_pkg::BLK_W-1:0]      fblk_reg, gblk_reg;
    logic [saa_pkg::IDX_W-1:0]      fslot_reg, gslot_reg;
    logic [1:0]                     status_reg;
    logic [71:0]                    out_data_reg;
    logic [1:0]                     out_status_reg;

    logic [saa_pkg::LIVE_W-1:0]     newlive;
    logic [13:0]                    grow_prod;
    logic [19:0]                    grow_lhs, grow_rhs;
    logic                           may_grow;
    logic                           all_full;
    logic                           store_full;
    logic [saa_pkg::SLOTS_PER_BLK-1:0] row, low_mask, free_bits;
    logic [saa_pkg::IDX_W-1:0]      found;
    logic                           hit;
    logic [6:0]                     skipped;
    logic [saa_pkg::SKIP_W:0]       skip_sum;
    logic [saa_pkg::SKIP_W-1:0]     skips_sat;
    logic [saa_pkg::BLK_W-1:0]      nb_cur;
    logic [saa_pkg::OPEN_W-1:0]     nb_open, cur_inc;
    logic                           free_ok;

    // Growth test against the opened capacity
    assign newlive   = live_reg + 1'b1;
    assign grow_lhs  = {1'b0, newlive, 8'd0};
    assign grow_prod = 14'(ff_reg) * 14'(opened_reg);
    assign grow_rhs  = {grow_prod, 6'd0};
    assign may_grow  = (opened_reg < saa_pkg::OPEN_W'(saa_pkg::MAX_BLOCKS))
                       && (grow_lhs > grow_rhs);

    // Flag a store with every opened block full
    always_comb
    begin
        all_full = 1'b1;
        for (int b = 0; b < saa_pkg::MAX_BLOCKS; b++)
            if ((saa_pkg::OPEN_W'(b) < opened_reg) && !(&used_map_reg[b]))
                all_full = 1'b0;
    end
    assign store_full = all_full && !may_grow;

    // Find the highest empty slot at or below the scan position
    assign row       = used_map_reg[cur_reg];
    assign low_mask  = {saa_pkg::SLOTS_PER_BLK{1'b1}} >> (TOP_IDX - scan_reg);
    assign free_bits = ~row & low_mask;
    assign hit       = |free_bits;
    always_comb
    begin
        found = '0;
        for (int i = 0; i < saa_pkg::SLOTS_PER_BLK; i++)
            if (free_bits[i])
                found = saa_pkg::IDX_W'(i);
    end
    assign skipped   = hit ? 7'(scan_reg - found) : 7'({1'b0, scan_reg} + 7'd1);
    assign skip_sum  = {1'b0, skips_reg} + {26'd0, skipped};
    assign skips_sat = skip_sum[saa_pkg::SKIP_W] ? '1 : skip_sum[saa_pkg::SKIP_W-1:0];

    // Next block: open a new one or move round-robin
    assign cur_inc = {1'b0, cur_reg} + 1'b1;
    always_comb
    begin
        if (may_grow)
        begin
            nb_cur  = opened_reg[saa_pkg::BLK_W-1:0];
            nb_open = opened_reg + 1'b1;
        end
        else
        begin
            nb_cur  = (cur_inc == opened_reg) ? '0 : cur_inc[saa_pkg::BLK_W-1:0];
            nb_open = opened_reg;
        end
    end

    assign free_ok = ({1'b0, fblk_reg} < opened_reg) && used_map_reg[fblk_reg][fslot_reg];

    assign sts.hit      = hit;
    assign sts.done_now = (req_reg == saa_pkg::REQ_FREE) || store_full;

    // Bitmap and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < saa_pkg::MAX_BLOCKS; b++)
                used_map_reg[b] <= '0;
            opened_reg <= saa_pkg::OPEN_W'(1);
            cur_reg    <= '0;
            scan_reg   <= TOP_IDX;
            live_reg   <= '0;
            peak_reg   <= '0;
            skips_reg  <= '0;
            ff_reg     <= saa_pkg::FF_W'(128);
        end
        else
        begin
            if (cfg_we)
                ff_reg <= cfg_wdata;
            if (cmd.exec && (req_reg == saa_pkg::REQ_FREE) && free_ok)
            begin
                used_map_reg[fblk_reg][fslot_reg] <= 1'b0;
                live_reg <= live_reg - 1'b1;
            end
            if (cmd.step)
            begin
                skips_reg <= skips_sat;
                if (hit)
                begin
                    used_map_reg[cur_reg][found] <= 1'b1;
                    live_reg <= newlive;
                    if (newlive > peak_reg)
                        peak_reg <= newlive;
                    if (found == '0)
                    begin
                        scan_reg   <= TOP_IDX;
                        cur_reg    <= nb_cur;
                        opened_reg <= nb_open;
                    end
                    else
                        scan_reg <= found - 1'b1;
                end
                else
                begin
                    scan_reg   <= TOP_IDX;
                    cur_reg    <= nb_cur;
                    opened_reg <= nb_open;
                end
            end
        end
    end

    // Request, grant and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_req;
            fblk_reg  <= in_blk;
            fslot_reg <= in_slot;
        end
        if (cmd.exec)
        begin
            gblk_reg  <= '0;
            gslot_reg <= '0;
            if (req_reg == saa_pkg::REQ_FREE)
                status_reg <= free_ok ? saa_pkg::ST_OK : saa_pkg::ST_EMPTY;
            else
                status_reg <= store_full ? saa_pkg::ST_FULL : saa_pkg::ST_OK;
        end
        if (cmd.step && hit)
        begin
            gblk_reg  <= cur_reg;
            gslot_reg <= found;
        end
        if (cmd.load)
        begin
            out_data_reg   <= {3'd0, opened_reg, skips_reg, peak_reg, live_reg,
                               gslot_reg, gblk_reg};
            out_status_reg <= status_reg;
        end
    end

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

    `SAA_ASSERT(a_live_range, live_reg <= saa_pkg::LIVE_W'(1024))
    `SAA_ASSERT(a_opened_low, opened_reg >= saa_pkg::OPEN_W'(1))
    `SAA_ASSERT(a_opened_high, opened_reg <= saa_pkg::OPEN_W'(saa_pkg::MAX_BLOCKS))
    `SAA_ASSERT(a_peak_covers_live, peak_reg >= live_reg)
    `SAA_ASSERT(a_cur_opened, {1'b0, cur_reg} < opened_reg)
endmodule
`default_nettype wire

[rtl/core/slot_arena_allocator.sv]
// Top level of the slot arena allocator
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser req_type, s_tdata free_block, free_slot
//  m_*       out  m_tvalid/m_tready  m_tuser status, m_tdata grant and counters
//  cfg_*     in   cfg_we             cfg_wdata fill_factor_q8
// A free or a store-full allocate goes from execute straight to hand-off; a granted
// allocate first passes through the scan state, which examines one block per cycle
// until it finds an empty slot.
// Reset clears every used mark at once; no clearing pass is needed.
// A waiting result sits in the output register; the next transaction is taken
// meanwhile and stalls only at hand-off.
`timescale 1ns / 1ps
`default_nettype none
module slot_arena_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // free_block[3:0], free_slot[9:4], zero
    input  wire logic        s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // block_index[3:0], slot_index[9:4],
                                        // live_count[20:10], max_live[31:21],
                                        // skip_count[63:32], opened_blocks[68:64]
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata
);
    saa_pkg::cmd_t cmd;
    saa_pkg::sts_t sts;

    saa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    saa_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_req     (s_tuser),
        .in_blk     (s_tdata[3:0]),
        .in_slot    (s_tdata[9:4]),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );
endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the slot arena allocator
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    localparam int N_ROWS = 17;

    typedef struct packed {
        logic [3:0]  blk;
        logic [5:0]  slot;
        logic [1:0]  status;
        logic [10:0] live;
        logic [10:0] peak;
        logic [31:0] skips;
        logic [4:0]  opened;
    } grant_t;

    typedef struct {
        logic   req;
        int     blk;
        int     slot;
        bit     typed;
        grant_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    // shadow state of the allocator
    logic [63:0] slot_map [saa_pkg::MAX_BLOCKS];
    int unsigned blocks_open, cur_blk, scan_pos, live_now, live_peak, skips_sum, fill_q8;

    grant_t      pending_q[$];
    row_t        rows [N_ROWS];
    int          errors = 0;
    int          tx_idle = 0, rx_idle = 0;
    int          n_grants = 0, n_full = 0, n_empty = 0, n_frees = 0;
    longint      cycles = 0;

    slot_arena_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit can_grow(int unsigned live);
        longint lhs, rhs;
        lhs = longint'(live) * 256;
        rhs = longint'(fill_q8) * saa_pkg::SLOTS_PER_BLK * blocks_open;
        return blocks_open < saa_pkg::MAX_BLOCKS && lhs > rhs;
    endfunction

    function automatic void next_block(int unsigned live);
        if (can_grow(live))
        begin
            cur_blk = blocks_open;
            blocks_open++;
        end
        else
            cur_blk = (cur_blk + 1) % blocks_open;
    endfunction

    function automatic grant_t snapshot(int unsigned b, int unsigned s, logic [1:0] st);
        grant_t g;
        g.blk = b[3:0];
        g.slot = s[5:0];
        g.status = st;
        g.live = live_now[10:0];
        g.peak = live_peak[10:0];
        g.skips = skips_sum;
        g.opened = blocks_open[4:0];
        return g;
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic grant_t predict_request(logic req, int unsigned b, int unsigned s);
        bit          full_all;
        int unsigned idx, newlive, steps, gb;
        if (req == saa_pkg::REQ_FREE)
        begin
            if (b < blocks_open && slot_map[b][s])
            begin
                slot_map[b][s] = 1'b0;
                live_now--;
                return snapshot(0, 0, saa_pkg::ST_OK);
            end
            return snapshot(0, 0, saa_pkg::ST_EMPTY);
        end
        full_all = 1'b1;
        for (int i = 0; i < blocks_open; i++)
            if (slot_map[i] != '1)
                full_all = 1'b0;
        newlive = live_now + 1;
        if (full_all && !can_grow(newlive))
            return snapshot(0, 0, saa_pkg::ST_FULL);
        idx = scan_pos;
        steps = 0;
        while (slot_map[cur_blk][idx])
        begin
            steps++;
            if (steps > (saa_pkg::MAX_BLOCKS + 2) * saa_pkg::SLOTS_PER_BLK)
                return snapshot(0, 0, saa_pkg::ST_FULL);
            if (skips_sum != 32'hffff_ffff)
                skips_sum++;
            if (idx == 0)
            begin
                next_block(newlive);
                idx = saa_pkg::SLOTS_PER_BLK - 1;
            end
            else
                idx--;
        end
        live_now = newlive;
        if (newlive > live_peak)
            live_peak = newlive;
        slot_map[cur_blk][idx] = 1'b1;
        gb = cur_blk;
        if (idx == 0)
        begin
            scan_pos = saa_pkg::SLOTS_PER_BLK - 1;
            next_block(newlive);
        end
        else
            scan_pos = idx - 1;
        return snapshot(gb, idx, saa_pkg::ST_OK);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Send one transaction; record its expected result once accepted
    task automatic send(logic req, int unsigned b, int unsigned s, bit typed, grant_t typed_res);
        grant_t g;
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, s[5:0], b[3:0]};
        do @(posedge clk); while (!s_tready);
        g = predict_request(req, b, s);
        pending_q.insert(pending_q.size(), typed ? typed_res : g);
    endtask

    // Let all results drain, then the tail of any scan
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_fill(int unsigned v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[8:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        fill_q8 = v;
    endtask

    // Random phase: allocations at the given share, the rest mostly frees of live slots, some stray frees
    task automatic random_phase(int count, int alloc_pct);
        int unsigned b, s;
        bit          found;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // hold the sender until every result is back
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(99) < alloc_pct)
                send(saa_pkg::REQ_ALLOC, $urandom_range(15), $urandom_range(63), 0, '0);
            else if ($urandom_range(9) < 8 && live_now != 0)
            begin
                found = 0;
                while (!found)
                begin
                    b = $urandom_range(blocks_open - 1);
                    if (slot_map[b] != 0)
                    begin
                        s = $urandom_range(63);
                        while (!slot_map[b][s])
                            s = (s + 1) % 64;
                        found = 1;
                    end
                end
                send(saa_pkg::REQ_FREE, b, s, 0, '0);
            end
            else
                send(saa_pkg::REQ_FREE, $urandom_range(15), $urandom_range(63), 0, '0);
        end
    endtask

    // Receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        grant_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.blk    = m_tdata[3:0];
            got.slot   = m_tdata[9:4];
            got.live   = m_tdata[20:10];
            got.peak   = m_tdata[31:21];
            got.skips  = m_tdata[63:32];
            got.opened = m_tdata[68:64];
            got.status = m_tuser;
            if (pending_q.size() == 0)
                report("unexpected result count", 1, 0);
            else
            begin
                want = pending_q.pop_front();
                if (got.blk != want.blk) report("block_index", got.blk, want.blk);
                if (got.slot != want.slot) report("slot_index", got.slot, want.slot);
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.live != want.live) report("live_count", got.live, want.live);
                if (got.peak != want.peak) report("max_live", got.peak, want.peak);
                if (got.skips != want.skips) report("skip_count", got.skips, want.skips);
                if (got.opened != want.opened)
                    report("opened_blocks", got.opened, want.opened);
                case (want.status)
                    saa_pkg::ST_FULL:  n_full++;
                    saa_pkg::ST_EMPTY: n_empty++;
                    default:  if (want.slot != 0 || want.blk != 0) n_grants++;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 900000)
        begin
            $display("timeout with %0d results outstanding", pending_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < saa_pkg::MAX_BLOCKS; i++)
            slot_map[i] = '0;
        blocks_open = 1;
        cur_blk = 0;
        scan_pos = saa_pkg::SLOTS_PER_BLK - 1;
        live_now = 0;
        live_peak = 0;
        skips_sum = 0;
        fill_q8 = 128;

        // rows 0 to 8 carry their expected status, live, peak, skips and opened, traced from the reset state
        rows[0]  = '{saa_pkg::REQ_FREE,  0,  0, 1, '{0, 0, saa_pkg::ST_EMPTY, 0, 0, 0, 1}};
        rows[1]  = '{saa_pkg::REQ_ALLOC, 0,  0, 1, '{0, 63, saa_pkg::ST_OK, 1, 1, 0, 1}};
        rows[2]  = '{saa_pkg::REQ_ALLOC, 15, 63, 1, '{0, 62, saa_pkg::ST_OK, 2, 2, 0, 1}};
        rows[3]  = '{saa_pkg::REQ_FREE,  0, 63, 1, '{0, 0, saa_pkg::ST_OK, 1, 2, 0, 1}};
        rows[4]  = '{saa_pkg::REQ_FREE,  0, 63, 1, '{0, 0, saa_pkg::ST_EMPTY, 1, 2, 0, 1}};
        rows[5]  = '{saa_pkg::REQ_FREE, 15, 63, 1, '{0, 0, saa_pkg::ST_EMPTY, 1, 2, 0, 1}};
        rows[6]  = '{saa_pkg::REQ_FREE,  8, 21, 1, '{0, 0, saa_pkg::ST_EMPTY, 1, 2, 0, 1}};
        rows[7]  = '{saa_pkg::REQ_FREE,  7, 42, 1, '{0, 0, saa_pkg::ST_EMPTY, 1, 2, 0, 1}};
        rows[8]  = '{saa_pkg::REQ_FREE,  0,  0, 1, '{0, 0, saa_pkg::ST_EMPTY, 1, 2, 0, 1}};
        rows[9]  = '{saa_pkg::REQ_ALLOC, 0,  0, 0, '0};
        rows[10] = '{saa_pkg::REQ_ALLOC, 0,  0, 0, '0};
        rows[11] = '{saa_pkg::REQ_FREE,  0, 62, 0, '0};
        rows[12] = '{saa_pkg::REQ_FREE,  0, 61, 0, '0};
        rows[13] = '{saa_pkg::REQ_ALLOC, 0,  0, 0, '0};
        rows[14] = '{saa_pkg::REQ_ALLOC, 0,  0, 0, '0};
        rows[15] = '{saa_pkg::REQ_FREE,  0, 60, 0, '0};
        rows[16] = '{saa_pkg::REQ_ALLOC, 0,  0, 0, '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].req, rows[i].blk, rows[i].slot, rows[i].typed, rows[i].res);
        drain();

        tx_idle = 23;
        rx_idle = 61;
        random_phase(500, 85);
        drain();

        // always grow while blocks remain
        set_fill(0);
        tx_idle = 61;
        rx_idle = 23;
        random_phase(400, 60);
        drain();

        // grow only once everything opened is full; run into a full store
        set_fill(256);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(700, 98);
        drain();

        set_fill(1);
        random_phase(200, 50);
        drain();

        set_fill(128);
        random_phase(60, 70);
        drain();

        $display("covered %0d grants, %0d full-store and %0d empty-free results",
                 n_grants, n_full, n_empty);
        $display("fill factors 128, 0, 256, 1 and 128 again; %0d blocks opened at end",
                 blocks_open);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
